// File: rtl/boolean_network_attractor_finder_macros.svh
`ifndef BOOLEAN_NETWORK_ATTRACTOR_FINDER_MACROS_SVH
`define BOOLEAN_NETWORK_ATTRACTOR_FINDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BNAF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bnaf assertion failed");

// next-cycle implication, checked outside reset
`define BNAF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bnaf assertion failed");

`endif

// File: rtl/bnaf_pkg.sv
`timescale 1ns / 1ps

package bnaf_pkg;

    localparam int NODES       = 21;
    localparam int STATE_W     = NODES;
    localparam int MEET_W      = NODES + 1;
    localparam int CYC_W       = NODES;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [STATE_W-1:0] state_vec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEET,
        ST_CYCLE,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic       valid;
        state_vec_t state;
    } queue_head_t;

    function automatic state_vec_t net_next(input state_vec_t v);
        state_vec_t n;
        n[0]  = ~v[16];
        n[1]  = ~(v[15] & v[4]);
        n[2]  = v[5] & ~v[7];
        n[3]  = (v[1] | v[18] | v[10]) & ~v[4];
        n[4]  = ~(v[19] | v[0]);
        n[5]  = v[2];
        n[6]  = v[0] | v[19];
        n[7]  = ~v[5];
        n[8]  = ~v[17];
        n[9]  = v[19];
        n[10] = v[9] & ~v[4];
        n[11] = (v[5] | v[13]) & ~v[7];
        n[12] = v[15] & v[0] & ~v[4];
        n[13] = v[6];
        n[14] = v[15] & ~v[4];
        n[15] = (v[16] | v[9]) & ~v[12];
        n[16] = v[15] & ~(v[13] | v[10]);
        n[17] = v[18];
        n[18] = v[8];
        n[19] = v[11];
        n[20] = v[3] & ~v[14];
        return n;
    endfunction

endpackage

// File: rtl/boolean_network_attractor_finder.sv
// Each item runs in the engine through MEET, where meeting_steps counts the Floyd
// iterations, and CYCLE, which measures the attractor cycle length, before DONE.
// The single stepping unit in the back end runs one Floyd iteration or one cycle step per
// clock and takes a new item only once the last is done. A two-item input queue decouples.
// Reset: aresetn is synchronous, active low; it empties the queue, idles the engine and
// drops the output valid. Nothing else needs clearing.
`timescale 1ns / 1ps
`include "boolean_network_attractor_finder_macros.svh"

module boolean_network_attractor_finder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bnaf_pkg::STATE_W-1:0]  s_start_state,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bnaf_pkg::CYC_W-1:0]    m_cycle_length_minus_one,
    output logic [bnaf_pkg::MEET_W-1:0]   m_meeting_steps
);

    bnaf_pkg::queue_head_t head;
    logic                  pop;

    bnaf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_state (s_start_state),
        .pop           (pop),
        .head          (head)
    );

    bnaf_engine u_engine (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .head                     (head),
        .pop                      (pop),
        .m_valid                  (m_valid),
        .m_ready                  (m_ready),
        .m_cycle_length_minus_one (m_cycle_length_minus_one),
        .m_meeting_steps          (m_meeting_steps)
    );

    `BNAF_ASSERT_NEXT(a_push_fills_queue, aclk, aresetn, s_valid && s_ready, head.valid)
    `BNAF_ASSERT_NOW(a_meet_nonzero, aclk, aresetn, m_valid, m_meeting_steps != '0)
    `BNAF_ASSERT_NOW(a_pop_needs_item, aclk, aresetn, pop, head.valid)

endmodule

// File: rtl/bnaf_front.sv
`timescale 1ns / 1ps

module bnaf_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bnaf_pkg::state_vec_t  s_start_state,
    input  logic                  pop,
    output bnaf_pkg::queue_head_t head
);

    bnaf_pkg::state_vec_t                  mem_reg [bnaf_pkg::QUEUE_DEPTH];
    logic [bnaf_pkg::QPTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [bnaf_pkg::QPTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [bnaf_pkg::QCNT_W-1:0]           count_reg, count_next;
    logic                                  push;
    logic                                  do_pop;

    assign s_ready = (count_reg != bnaf_pkg::QCNT_W'(bnaf_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.state = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == bnaf_pkg::QPTR_W'(bnaf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == bnaf_pkg::QPTR_W'(bnaf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_start_state;
        end
    end

endmodule

// File: rtl/bnaf_engine.sv
`timescale 1ns / 1ps

module bnaf_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bnaf_pkg::queue_head_t         head,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bnaf_pkg::CYC_W-1:0]    m_cycle_length_minus_one,
    output logic [bnaf_pkg::MEET_W-1:0]   m_meeting_steps
);

    bnaf_pkg::eng_state_t              state_reg, state_next;
    bnaf_pkg::state_vec_t              slow_reg, slow_next;
    bnaf_pkg::state_vec_t              fast_reg, fast_next;
    logic [bnaf_pkg::MEET_W-1:0]       meet_reg, meet_next;
    logic [bnaf_pkg::CYC_W-1:0]        cnt_reg, cnt_next;
    logic                              m_valid_reg, m_valid_next;
    logic [bnaf_pkg::CYC_W-1:0]        m_cyc_reg, m_cyc_next;
    logic [bnaf_pkg::MEET_W-1:0]       m_meet_reg, m_meet_next;

    bnaf_pkg::state_vec_t              slow_step;
    bnaf_pkg::state_vec_t              fast_one;
    bnaf_pkg::state_vec_t              fast_two;
    logic                              out_free;
    logic                              load_out;

    assign slow_step = bnaf_pkg::net_next(slow_reg);
    assign fast_one  = bnaf_pkg::net_next(fast_reg);
    assign fast_two  = bnaf_pkg::net_next(fast_one);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bnaf_pkg::ST_IDLE: begin
                if (head.valid) state_next = bnaf_pkg::ST_MEET;
            end
            bnaf_pkg::ST_MEET: begin
                if (slow_step == fast_two) state_next = bnaf_pkg::ST_CYCLE;
            end
            bnaf_pkg::ST_CYCLE: begin
                if (fast_one == slow_reg) state_next = bnaf_pkg::ST_DONE;
            end
            bnaf_pkg::ST_DONE: begin
                if (out_free) state_next = bnaf_pkg::ST_IDLE;
            end
            default: state_next = bnaf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            bnaf_pkg::ST_IDLE: pop      = head.valid;
            bnaf_pkg::ST_DONE: load_out = out_free;
            default: begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_comb begin
        slow_next = slow_reg;
        fast_next = fast_reg;
        meet_next = meet_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            bnaf_pkg::ST_IDLE: begin
                slow_next = head.state;
                fast_next = head.state;
                meet_next = '0;
                cnt_next  = '0;
            end
            bnaf_pkg::ST_MEET: begin
                slow_next = slow_step;
                fast_next = fast_two;
                meet_next = meet_reg + 1'b1;
            end
            bnaf_pkg::ST_CYCLE: begin
                fast_next = fast_one;
                if (fast_one != slow_reg) cnt_next = cnt_reg + 1'b1;
            end
            default: begin
                slow_next = slow_reg;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_cyc_next   = m_cyc_reg;
        m_meet_next  = m_meet_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_cyc_next   = cnt_reg;
            m_meet_next  = meet_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bnaf_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slow_reg   <= slow_next;
        fast_reg   <= fast_next;
        meet_reg   <= meet_next;
        cnt_reg    <= cnt_next;
        m_cyc_reg  <= m_cyc_next;
        m_meet_reg <= m_meet_next;
    end

    assign m_valid                  = m_valid_reg;
    assign m_cycle_length_minus_one = m_cyc_reg;
    assign m_meeting_steps          = m_meet_reg;

endmodule
